// File: design/mbrtu_pkg.sv
`default_nettype none

package mbrtu_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

    localparam logic [7:0]  QTY_HI        = 8'h00;
    localparam logic [7:0]  QTY_LO        = 8'h01;
    localparam logic [7:0]  COUNT_ONE_REG = 8'h02;

    localparam int          TX_IDX_W      = 3;
    localparam logic [TX_IDX_W-1:0] TX_LAST_IDX = 3'd7;

    localparam int          CFG_IDX_W     = 1;
    localparam int          CFG_DATA_W    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDRESS = 1'b0,
        CFG_READ_FUNCTION = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        OP_SEND = 1'b0,
        OP_RECV = 1'b1
    } opcode_t;

    typedef enum logic {
        KIND_TX     = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_SHORT = 2'd2,
        ST_COUNT = 2'd3
    } status_t;

    typedef struct packed {
        logic       active;
        logic [7:0] data;
        logic       last;
    } tx_out_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/mbrtu_tx_seq.sv
`default_nettype none

module mbrtu_tx_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                advance,
    input  wire logic [7:0]          slave_address,
    input  wire logic [7:0]          read_function,
    input  wire logic [15:0]         start_address,
    output mbrtu_pkg::tx_out_t       tx_o
);
    import mbrtu_pkg::*;

    logic                active_reg, active_next;
    logic [TX_IDX_W-1:0] index_reg, index_next;
    logic [15:0]         crc_reg, crc_next;
    logic [7:0]          slave_reg, slave_next;
    logic [7:0]          func_reg, func_next;
    logic [15:0]         start_reg, start_next;
    logic [7:0]          cur_byte;

    always_comb
    begin
        unique case (index_reg)
            3'd0:    cur_byte = slave_reg;
            3'd1:    cur_byte = func_reg;
            3'd2:    cur_byte = start_reg[15:8];
            3'd3:    cur_byte = start_reg[7:0];
            3'd4:    cur_byte = QTY_HI;
            3'd5:    cur_byte = QTY_LO;
            3'd6:    cur_byte = crc_reg[7:0];
            default: cur_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        index_next  = index_reg;
        crc_next    = crc_reg;
        slave_next  = slave_reg;
        func_next   = func_reg;
        start_next  = start_reg;
        if (start)
        begin
            active_next = 1'b1;
            index_next  = '0;
            crc_next    = CRC_INIT;
            slave_next  = slave_address;
            func_next   = read_function;
            start_next  = start_address;
        end
        else if (active_reg && advance)
        begin
            index_next = index_reg + 1'b1;
            if (index_reg < 3'd6)
                crc_next = crc16_byte(crc_reg, cur_byte);
            if (index_reg == TX_LAST_IDX)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            index_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            index_reg  <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg   <= crc_next;
        slave_reg <= slave_next;
        func_reg  <= func_next;
        start_reg <= start_next;
    end

    assign tx_o.active = active_reg;
    assign tx_o.data   = cur_byte;
    assign tx_o.last   = (index_reg == TX_LAST_IDX);

endmodule

`default_nettype wire

// File: design/modbus_rtu_read_register_master.sv
// Receive transaction: one byte per cycle while in_ready is high (not during a send, nor
// while the output holds a value not yet taken); the report for a last byte is in the
// output register in the cycle after that byte is accepted. Send transaction: the eight
// request bytes enter the output register in order as the output frees, the first by way
// of the sequencer's active register; the input is held off while the sequencer is active.
// Reset clears config to address 1 and function 3, clears the frame and the output.
`default_nettype none

module modbus_rtu_read_register_master #(
    parameter int MAX_FRAME = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             opcode,
    input  wire logic [15:0]                      start_address,
    input  wire logic [7:0]                       rx_byte,
    input  wire logic                             rx_last,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  kind,
    output logic [7:0]                            tx_byte,
    output logic                                  tx_last,
    output logic signed [15:0]                    register_value,
    output logic [1:0]                            status,
    input  wire logic                             cfg_we,
    input  wire logic [mbrtu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mbrtu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mbrtu_pkg::*;

    localparam int LEN_W = $clog2(MAX_FRAME + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME);

    logic [7:0]       slave_reg, func_reg;

    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      delay_reg, delay_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       count_reg, count_next;
    logic [15:0]      value_reg, value_next;

    logic             out_valid_reg, out_valid_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       txb_reg, txb_next;
    logic             txl_reg, txl_next;
    logic [15:0]      val_reg, val_next;
    status_t          st_reg, st_next;

    logic             out_free;
    logic             accept;
    logic             send_go;
    logic             rx_go;
    tx_out_t          tx;
    logic [15:0]      rx_crc;
    status_t          rep_st;
    logic [15:0]      rep_val;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !tx.active && out_free;
    assign accept   = in_valid && in_ready;
    assign send_go  = accept && (opcode == OP_SEND);
    assign rx_go    = accept && (opcode == OP_RECV);

    mbrtu_tx_seq u_tx_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (send_go),
        .advance       (out_free),
        .slave_address (slave_reg),
        .read_function (func_reg),
        .start_address (start_address),
        .tx_o          (tx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= 8'd1;
            func_reg  <= 8'h03;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SLAVE_ADDRESS: slave_reg <= cfg_data;
                CFG_READ_FUNCTION: func_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        crc_next   = crc_reg;
        delay_next = delay_reg;
        len_next   = len_reg;
        count_next = count_reg;
        value_next = value_reg;
        if (len_reg < LEN_MAX)
        begin
            if (len_reg >= LEN_W'(2))
                crc_next = crc16_byte(crc_reg, delay_reg[15:8]);
            delay_next = {delay_reg[7:0], rx_byte};
            if (len_reg == LEN_W'(2))
                count_next = rx_byte;
            else if (len_reg == LEN_W'(3))
                value_next = {rx_byte, value_reg[7:0]};
            else if (len_reg == LEN_W'(4))
                value_next = {value_reg[15:8], rx_byte};
            len_next = len_reg + 1'b1;
        end
    end

    assign rx_crc = {delay_next[7:0], delay_next[15:8]};

    always_comb
    begin
        rep_val = 16'h0000;
        if (len_next < LEN_W'(2))
            rep_st = ST_SHORT;
        else if (rx_crc != crc_next)
            rep_st = ST_CRC;
        else if (len_next < LEN_W'(5))
            rep_st = ST_SHORT;
        else if (count_next != COUNT_ONE_REG)
            rep_st = ST_COUNT;
        else
        begin
            rep_st  = ST_OK;
            rep_val = value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            delay_reg <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            value_reg <= '0;
        end
        else if (send_go || (rx_go && rx_last))
        begin
            crc_reg   <= CRC_INIT;
            delay_reg <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            value_reg <= '0;
        end
        else if (rx_go)
        begin
            crc_reg   <= crc_next;
            delay_reg <= delay_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            value_reg <= value_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        txb_next       = txb_reg;
        txl_next       = txl_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        if (tx.active && out_free)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_TX;
            txb_next       = tx.data;
            txl_next       = tx.last;
            val_next       = 16'h0000;
            st_next        = ST_OK;
        end
        else if (rx_go && rx_last)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_REPORT;
            txb_next       = 8'h00;
            txl_next       = 1'b0;
            val_next       = rep_val;
            st_next        = rep_st;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        txb_reg  <= txb_next;
        txl_reg  <= txl_next;
        val_reg  <= val_next;
        st_reg   <= st_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign tx_byte        = txb_reg;
    assign tx_last        = txl_reg;
    assign register_value = val_reg;
    assign status         = st_reg;

`ifndef SYNTH
    a_send_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == OP_SEND) |=> tx.active)
        else $error("send transaction did not start the tx sequencer");

    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_REPORT && status != ST_OK) |-> register_value == 16'sd0)
        else $error("error report carries a nonzero value");

    a_tx_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_last) |-> kind == KIND_TX)
        else $error("tx_last set on a report");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_MAX)
        else $error("frame length past maximum");
`endif

endmodule

`default_nettype wire
